>>> rtl/lwbpb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_pkg
// Shared types and constants of the LRU write-back page buffer.
// ----------------------------------------------------------------------------
package lwbpb_pkg;

  localparam int ENTRIES_DEF     = 16;
  localparam int OBJECT_BITS_DEF = 16;
  localparam int PAGE_BITS_DEF   = 20;
  localparam int HANDLE_BITS     = 32;
  localparam int CMD_BITS        = 3;
  localparam int ACT_BITS        = 3;

  // request commands, the remaining codes act as no-ops
  typedef enum logic [CMD_BITS-1:0] {
    CMD_READ          = 3'd0,
    CMD_WRITE_THROUGH = 3'd1,
    CMD_BUF_WRITE     = 3'd2,
    CMD_UNBUFFER      = 3'd3,
    CMD_TERMINATE     = 3'd4
  } cmd_e;

  // result actions
  typedef enum logic [ACT_BITS-1:0] {
    ACT_DONE     = 3'd0,
    ACT_FWD_READ = 3'd1,
    ACT_SUPPLY   = 3'd2,
    ACT_WRITE    = 3'd3,
    ACT_DISCARD  = 3'd4,
    ACT_FWD_TERM = 3'd5
  } act_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SCAN_LAST,
    ST_DECIDE,
    ST_WT2,
    ST_EVICT,
    ST_TFIND,
    ST_TEMIT,
    ST_TDONE
  } state_e;

  // rank bookkeeping operations
  typedef enum logic [2:0] {
    RK_NONE,
    RK_TOUCH,
    RK_REMOVE,
    RK_INSERT,
    RK_REPLACE
  } rank_op_e;

endpackage

>>> rtl/lwbpb_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lwbpb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds when not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/lru_write_back_page_buffer.sv
`timescale 1ns / 1ps
// Read, write-through, unbuffer and buffered write scan the tags of all entries
// before the first result; an eviction first reads the victim word from the RAM.
// Terminate: the tag scan, then a search of the insertion ranks in order that
// reads and writes out each matching entry, then the final beat.
// One request at a time; the serial tag scan through the single RAM read port sets it.
// Reset frees all entries at once; no clearing pass.
// ----------------------------------------------------------------------------
// lru_write_back_page_buffer
// LRU write-back buffer of page-data handles keyed by object id and page.
// ----------------------------------------------------------------------------
module lru_write_back_page_buffer #(
  parameter int ENTRIES     = lwbpb_pkg::ENTRIES_DEF,
  parameter int OBJECT_BITS = lwbpb_pkg::OBJECT_BITS_DEF,
  parameter int PAGE_BITS   = lwbpb_pkg::PAGE_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [lwbpb_pkg::CMD_BITS-1:0]   cmd_i,
  input  logic [OBJECT_BITS-1:0]           object_id_i,
  input  logic [PAGE_BITS-1:0]             page_number_i,
  input  logic [lwbpb_pkg::HANDLE_BITS-1:0] data_handle_i,
  input  logic                             clean_flag_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [lwbpb_pkg::ACT_BITS-1:0]   action_o,
  output logic [OBJECT_BITS-1:0]           out_object_o,
  output logic [PAGE_BITS-1:0]             out_page_o,
  output logic [lwbpb_pkg::HANDLE_BITS-1:0] out_handle_o,
  output logic                             last_o
);

  localparam int IDX_W  = $clog2(ENTRIES);
  localparam int CNT_W  = $clog2(ENTRIES + 1);
  localparam int HDL_W  = lwbpb_pkg::HANDLE_BITS;
  localparam int WORD_W = OBJECT_BITS + PAGE_BITS + HDL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  lwbpb_pkg::state_e state_q, state_d;

  // request registers
  lwbpb_pkg::cmd_e          cmd_q;
  logic [OBJECT_BITS-1:0]   obj_q;
  logic [PAGE_BITS-1:0]     page_q;
  logic [HDL_W-1:0]         hdl_q;
  logic                     clean_q;

  // scan registers
  logic [IDX_W-1:0]         idx_q;
  logic                     cmp_vld_q;
  logic [IDX_W-1:0]         cmp_idx_q;
  logic                     hit_q;
  logic [IDX_W-1:0]         hit_idx_q;
  logic [HDL_W-1:0]         hit_hdl_q;
  logic [ENTRIES-1:0]       mask_q;
  logic [IDX_W-1:0]         term_r_q;
  logic [IDX_W-1:0]         sel_q;

  // entry bookkeeping
  logic [ENTRIES-1:0]       valid_q, valid_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [IDX_W-1:0]         age_q [ENTRIES];
  logic [IDX_W-1:0]         age_d [ENTRIES];
  logic [IDX_W-1:0]         ins_q [ENTRIES];
  logic [IDX_W-1:0]         ins_d [ENTRIES];

  // output register
  logic                     out_valid_q;
  lwbpb_pkg::act_e          out_act_q;
  logic [OBJECT_BITS-1:0]   out_obj_q;
  logic [PAGE_BITS-1:0]     out_page_q;
  logic [HDL_W-1:0]         out_hdl_q;
  logic                     out_last_q;

  // ram
  logic                     ram_we, ram_re;
  logic [IDX_W-1:0]         ram_waddr, ram_raddr;
  logic [WORD_W-1:0]        ram_wdata, ram_rdata;
  logic [OBJECT_BITS-1:0]   rd_obj;
  logic [PAGE_BITS-1:0]     rd_page;
  logic [HDL_W-1:0]         rd_hdl;

  // control
  logic                     accept, out_free, full, cmp_match;
  logic [IDX_W-1:0]         free_idx, victim_idx, term_idx;
  logic                     term_found;
  logic                     emit;
  lwbpb_pkg::act_e          e_act;
  logic [PAGE_BITS-1:0]     e_page;
  logic [OBJECT_BITS-1:0]   e_obj;
  logic [HDL_W-1:0]         e_hdl;
  logic                     e_last;
  lwbpb_pkg::rank_op_e      rk_op;
  logic [IDX_W-1:0]         rk_idx;
  logic [IDX_W-1:0]         rk_age, rk_ins;

  lwbpb_ram #(
    .WIDTH (WORD_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign {rd_obj, rd_page, rd_hdl} = ram_rdata;
  assign ram_wdata = {obj_q, page_q, hdl_q};

  assign in_stall_o = (state_q != lwbpb_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (cnt_q == CNT_W'(ENTRIES));

  // tag compare on the word read in the previous cycle
  assign cmp_match = cmp_vld_q && valid_q[cmp_idx_q] && (rd_obj == obj_q) &&
                     ((cmd_q == lwbpb_pkg::CMD_TERMINATE) || (rd_page == page_q));

  // lowest free entry, lru victim, next terminate entry
  always_comb begin
    free_idx   = '0;
    victim_idx = '0;
    term_idx   = '0;
    term_found = 1'b0;
    for (int j = ENTRIES - 1; j >= 0; j--) begin
      if (!valid_q[j]) begin
        free_idx = IDX_W'(j);
      end
      if (valid_q[j] && (age_q[j] == '0)) begin
        victim_idx = IDX_W'(j);
      end
      if (valid_q[j] && mask_q[j] && (ins_q[j] == term_r_q)) begin
        term_idx   = IDX_W'(j);
        term_found = 1'b1;
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lwbpb_pkg::ST_IDLE: begin
        if (accept) state_d = lwbpb_pkg::ST_SCAN;
      end
      lwbpb_pkg::ST_SCAN: begin
        if (idx_q == LAST_IDX) state_d = lwbpb_pkg::ST_SCAN_LAST;
      end
      lwbpb_pkg::ST_SCAN_LAST: begin
        state_d = lwbpb_pkg::ST_DECIDE;
      end
      lwbpb_pkg::ST_DECIDE: begin
        unique case (cmd_q)
          lwbpb_pkg::CMD_WRITE_THROUGH: begin
            if (out_free) state_d = hit_q ? lwbpb_pkg::ST_WT2 : lwbpb_pkg::ST_IDLE;
          end
          lwbpb_pkg::CMD_BUF_WRITE: begin
            if (!hit_q && full) begin
              state_d = lwbpb_pkg::ST_EVICT;
            end else if (out_free) begin
              state_d = lwbpb_pkg::ST_IDLE;
            end
          end
          lwbpb_pkg::CMD_TERMINATE: begin
            state_d = lwbpb_pkg::ST_TFIND;
          end
          default: begin
            if (out_free) state_d = lwbpb_pkg::ST_IDLE;
          end
        endcase
      end
      lwbpb_pkg::ST_WT2, lwbpb_pkg::ST_EVICT, lwbpb_pkg::ST_TDONE: begin
        if (out_free) state_d = lwbpb_pkg::ST_IDLE;
      end
      lwbpb_pkg::ST_TFIND: begin
        if (term_found) begin
          state_d = lwbpb_pkg::ST_TEMIT;
        end else if (term_r_q == LAST_IDX) begin
          state_d = lwbpb_pkg::ST_TDONE;
        end
      end
      lwbpb_pkg::ST_TEMIT: begin
        if (out_free) state_d = lwbpb_pkg::ST_TFIND;
      end
      default: state_d = lwbpb_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: ram access, result beat, rank operation
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    ram_we    = 1'b0;
    ram_waddr = hit_idx_q;
    emit      = 1'b0;
    e_act     = lwbpb_pkg::ACT_DONE;
    e_obj     = obj_q;
    e_page    = page_q;
    e_hdl     = '0;
    e_last    = 1'b1;
    rk_op     = lwbpb_pkg::RK_NONE;
    rk_idx    = hit_idx_q;
    unique case (state_q)
      lwbpb_pkg::ST_SCAN: begin
        ram_re = 1'b1;
      end
      lwbpb_pkg::ST_DECIDE: begin
        unique case (cmd_q)
          lwbpb_pkg::CMD_READ: begin
            emit = out_free;
            if (hit_q) begin
              e_act = lwbpb_pkg::ACT_SUPPLY;
              e_hdl = hit_hdl_q;
              if (out_free) rk_op = lwbpb_pkg::RK_TOUCH;
            end else begin
              e_act = lwbpb_pkg::ACT_FWD_READ;
            end
          end
          lwbpb_pkg::CMD_WRITE_THROUGH: begin
            emit = out_free;
            if (hit_q) begin
              e_act  = lwbpb_pkg::ACT_DISCARD;
              e_hdl  = hit_hdl_q;
              e_last = 1'b0;
              if (out_free) rk_op = lwbpb_pkg::RK_REMOVE;
            end else begin
              e_act = lwbpb_pkg::ACT_WRITE;
              e_hdl = hdl_q;
            end
          end
          lwbpb_pkg::CMD_BUF_WRITE: begin
            if (hit_q) begin
              emit  = out_free;
              e_act = lwbpb_pkg::ACT_DISCARD;
              e_hdl = hit_hdl_q;
              if (out_free) begin
                ram_we = 1'b1;
                rk_op  = lwbpb_pkg::RK_TOUCH;
              end
            end else if (!full) begin
              emit      = out_free;
              e_hdl     = hdl_q;
              ram_waddr = free_idx;
              rk_idx    = free_idx;
              if (out_free) begin
                ram_we = 1'b1;
                rk_op  = lwbpb_pkg::RK_INSERT;
              end
            end else begin
              ram_re    = 1'b1;
              ram_raddr = victim_idx;
            end
          end
          lwbpb_pkg::CMD_UNBUFFER: begin
            emit = out_free;
            if (hit_q) begin
              e_act = clean_q ? lwbpb_pkg::ACT_WRITE : lwbpb_pkg::ACT_DISCARD;
              e_hdl = hit_hdl_q;
              if (out_free) rk_op = lwbpb_pkg::RK_REMOVE;
            end
          end
          lwbpb_pkg::CMD_TERMINATE: begin
            emit = 1'b0;
          end
          default: begin
            emit = out_free;
          end
        endcase
      end
      lwbpb_pkg::ST_WT2: begin
        emit  = out_free;
        e_act = lwbpb_pkg::ACT_WRITE;
        e_hdl = hdl_q;
      end
      lwbpb_pkg::ST_EVICT: begin
        emit      = out_free;
        e_act     = lwbpb_pkg::ACT_WRITE;
        e_obj     = rd_obj;
        e_page    = rd_page;
        e_hdl     = rd_hdl;
        ram_waddr = sel_q;
        rk_idx    = sel_q;
        if (out_free) begin
          ram_we = 1'b1;
          rk_op  = lwbpb_pkg::RK_REPLACE;
        end
      end
      lwbpb_pkg::ST_TFIND: begin
        ram_re    = term_found;
        ram_raddr = term_idx;
      end
      lwbpb_pkg::ST_TEMIT: begin
        emit   = out_free;
        e_act  = lwbpb_pkg::ACT_WRITE;
        e_page = rd_page;
        e_hdl  = rd_hdl;
        e_last = 1'b0;
        rk_idx = sel_q;
        if (out_free) rk_op = lwbpb_pkg::RK_REMOVE;
      end
      lwbpb_pkg::ST_TDONE: begin
        emit   = out_free;
        e_act  = lwbpb_pkg::ACT_FWD_TERM;
        e_page = '0;
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // age and insertion rank bookkeeping, one lane per entry
  assign rk_age = age_q[rk_idx];
  assign rk_ins = ins_q[rk_idx];

  always_comb begin
    valid_d = valid_q;
    cnt_d   = cnt_q;
    age_d   = age_q;
    ins_d   = ins_q;
    unique case (rk_op)
      lwbpb_pkg::RK_TOUCH: begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j] && (age_q[j] > rk_age)) age_d[j] = age_q[j] - 1'b1;
        end
        age_d[rk_idx] = IDX_W'(cnt_q - 1'b1);
      end
      lwbpb_pkg::RK_REMOVE, lwbpb_pkg::RK_REPLACE: begin
        for (int j = 0; j < ENTRIES; j++) begin
          if (valid_q[j] && (IDX_W'(j) != rk_idx)) begin
            if (age_q[j] > rk_age) age_d[j] = age_q[j] - 1'b1;
            if (ins_q[j] > rk_ins) ins_d[j] = ins_q[j] - 1'b1;
          end
        end
        if (rk_op == lwbpb_pkg::RK_REMOVE) begin
          valid_d[rk_idx] = 1'b0;
          cnt_d           = cnt_q - 1'b1;
        end else begin
          age_d[rk_idx] = LAST_IDX;
          ins_d[rk_idx] = LAST_IDX;
        end
      end
      lwbpb_pkg::RK_INSERT: begin
        valid_d[rk_idx] = 1'b1;
        age_d[rk_idx]   = cnt_q[IDX_W-1:0];
        ins_d[rk_idx]   = cnt_q[IDX_W-1:0];
        cnt_d           = cnt_q + 1'b1;
      end
      default: begin
        cnt_d = cnt_q;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lwbpb_pkg::ST_IDLE;
      valid_q     <= '0;
      cnt_q       <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      cmp_vld_q   <= (state_q == lwbpb_pkg::ST_SCAN);
      out_valid_q <= emit || (out_valid_q && out_stall_i);
    end
  end

  // ranks, request and scan data
  always_ff @(posedge clk_i) begin
    age_q     <= age_d;
    ins_q     <= ins_d;
    cmp_idx_q <= idx_q;
    if (accept) begin
      cmd_q   <= lwbpb_pkg::cmd_e'(cmd_i);
      obj_q   <= object_id_i;
      page_q  <= page_number_i;
      hdl_q   <= data_handle_i;
      clean_q <= clean_flag_i;
      idx_q   <= '0;
      hit_q   <= 1'b0;
      mask_q  <= '0;
    end else if (state_q == lwbpb_pkg::ST_SCAN && idx_q != LAST_IDX) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmp_match) begin
      if (cmd_q == lwbpb_pkg::CMD_TERMINATE) begin
        mask_q[cmp_idx_q] <= 1'b1;
      end else begin
        hit_q     <= 1'b1;
        hit_idx_q <= cmp_idx_q;
        hit_hdl_q <= rd_hdl;
      end
    end
    if (state_q == lwbpb_pkg::ST_DECIDE) begin
      term_r_q <= '0;
      sel_q    <= victim_idx;
    end else if (state_q == lwbpb_pkg::ST_TFIND) begin
      if (term_found) begin
        sel_q <= term_idx;
      end else if (term_r_q != LAST_IDX) begin
        term_r_q <= term_r_q + 1'b1;
      end
    end
  end

  // result beat register
  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_act_q  <= e_act;
      out_obj_q  <= e_obj;
      out_page_q <= e_page;
      out_hdl_q  <= e_hdl;
      out_last_q <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign action_o     = out_act_q;
  assign out_object_o = out_obj_q;
  assign out_page_o   = out_page_q;
  assign out_handle_o = out_hdl_q;
  assign last_o       = out_last_q;

endmodule

>>> rtl/lwbpb_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lwbpb_chk
// Port-level checks of the page buffer, bound to the top level.
// ----------------------------------------------------------------------------
module lwbpb_chk #(
  parameter int OBJECT_BITS = lwbpb_pkg::OBJECT_BITS_DEF,
  parameter int PAGE_BITS   = lwbpb_pkg::PAGE_BITS_DEF
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [lwbpb_pkg::ACT_BITS-1:0]    action_o,
  input logic [OBJECT_BITS-1:0]            out_object_o,
  input logic [PAGE_BITS-1:0]              out_page_o,
  input logic [lwbpb_pkg::HANDLE_BITS-1:0] out_handle_o,
  input logic                              last_o
);

  // stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(action_o) && $stable(out_object_o) &&
      $stable(out_page_o) && $stable(out_handle_o) && $stable(last_o))
    else $error("stalled result payload changed");

  // one request at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("request taken while busy");

  // single-result actions always close the request
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (action_o == lwbpb_pkg::ACT_DONE ||
      action_o == lwbpb_pkg::ACT_FWD_READ || action_o == lwbpb_pkg::ACT_SUPPLY ||
      action_o == lwbpb_pkg::ACT_FWD_TERM) |-> last_o)
    else $error("closing action without last");

  // forwarded terminate carries no page or handle
  a_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && action_o == lwbpb_pkg::ACT_FWD_TERM |->
      out_page_o == '0 && out_handle_o == '0)
    else $error("forwarded terminate with page or handle");

endmodule

bind lru_write_back_page_buffer lwbpb_chk #(
  .OBJECT_BITS (OBJECT_BITS),
  .PAGE_BITS   (PAGE_BITS)
) u_lwbpb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .action_o     (action_o),
  .out_object_o (out_object_o),
  .out_page_o   (out_page_o),
  .out_handle_o (out_handle_o),
  .last_o       (last_o)
);
